// ----- design/ffha_pkg.sv -----
// Shared types and constants for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OOM  = 2'd1;
   localparam logic [1:0] ST_NULL = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_BYTES = 1'b1;

   localparam logic [31:0] HEAP_BASE_RST  = 32'd33554432;
   localparam logic [31:0] HEAP_BYTES_RST = 32'd4194304;
   localparam logic [31:0] MAX_ROUNDABLE  = 32'hFFFF_FFFC;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // one segment: data address, data size, free flag
   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] size;
      logic        free;
   } seg_type;

   // request word travelling down the cell row
   typedef struct packed {
      logic        valid;
      logic        mode;
      logic [31:0] key;
      logic        done;
      logic [1:0]  status;
      logic [31:0] addr;
      logic        prev_free;
      logic        carry;
      seg_type     carry_seg;
      logic        shl;
      logic [1:0]  shamt;
   } probe_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] amount;
   } absorb_type;

endpackage
`default_nettype wire

// ----- design/ffha_cell.sv -----
// One table cell: holds a segment and processes the request word passing by.
`default_nettype none
module ffha_cell #(
   parameter int MAX_SEGMENTS = 64,
   parameter int HEADER_BYTES = 12,
   parameter int IDX          = 0,
   parameter int CW           = 7
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ffha_pkg::probe_type  probe_in,
   output ffha_pkg::probe_type       probe_out,
   input  wire logic [CW-1:0]        count,
   input  wire ffha_pkg::seg_type    next1,
   input  wire ffha_pkg::seg_type    next2,
   input  wire logic                 init,
   input  wire ffha_pkg::seg_type    init_seg,
   input  wire ffha_pkg::absorb_type absorb_in,
   output ffha_pkg::absorb_type      absorb_out,
   output ffha_pkg::seg_type         seg_out
);
   import ffha_pkg::*;

   localparam logic [31:0] HDR    = 32'(HEADER_BYTES);
   localparam logic [CW:0] IDX_W  = (CW+1)'(IDX);
   localparam logic [CW:0] IDX_P1 = (CW+1)'(IDX + 1);
   localparam logic [CW:0] MAXS   = (CW+1)'(MAX_SEGMENTS);

   probe_type probe_ff;
   seg_type   seg_ff, seg_in;
   logic      live, nf;
   logic [31:0] total;
   logic [32:0] split_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff.valid <= probe_in.valid;
      end
      probe_ff.mode      <= probe_in.mode;
      probe_ff.key       <= probe_in.key;
      probe_ff.done      <= probe_in.done;
      probe_ff.status    <= probe_in.status;
      probe_ff.addr      <= probe_in.addr;
      probe_ff.prev_free <= probe_in.prev_free;
      probe_ff.carry     <= probe_in.carry;
      probe_ff.carry_seg <= probe_in.carry_seg;
      probe_ff.shl       <= probe_in.shl;
      probe_ff.shamt     <= probe_in.shamt;
      seg_ff <= seg_in;
   end

   assign live      = IDX_W < {1'b0, count};
   assign nf        = next1.free && (IDX_P1 < {1'b0, count});
   assign total     = seg_ff.size + (nf ? HDR + next1.size : 32'd0);
   assign split_lim = {1'b0, probe_ff.key} + {1'b0, HDR} + 33'd4;

   always_comb begin
      seg_in     = seg_ff;
      probe_out  = probe_ff;
      absorb_out = '0;
      probe_out.prev_free = seg_ff.free && live;
      if (probe_ff.valid) begin
         if (probe_ff.shl) begin
            // close the gap left by merged segments
            seg_in = (probe_ff.shamt == 2'd1) ? next1 : next2;
         end else if (probe_ff.carry) begin
            seg_in = probe_ff.carry_seg;
            probe_out.carry_seg = seg_ff;
         end else if (!probe_ff.done && live) begin
            if (probe_ff.mode == MODE_ALLOC) begin
               if (seg_ff.free && seg_ff.size >= probe_ff.key) begin
                  probe_out.done   = 1'b1;
                  probe_out.status = ST_OK;
                  probe_out.addr   = seg_ff.addr;
                  seg_in.free      = 1'b0;
                  if ({1'b0, seg_ff.size} > split_lim && {1'b0, count} < MAXS) begin
                     seg_in.size = probe_ff.key;
                     probe_out.carry          = 1'b1;
                     probe_out.carry_seg.addr = seg_ff.addr + HDR + probe_ff.key;
                     probe_out.carry_seg.size = seg_ff.size - probe_ff.key - HDR;
                     probe_out.carry_seg.free = 1'b1;
                  end
               end
            end else if (seg_ff.addr == probe_ff.key) begin
               probe_out.done   = 1'b1;
               probe_out.status = ST_OK;
               if (probe_ff.prev_free) begin
                  // fold into the left neighbor, drop this entry
                  absorb_out.valid  = 1'b1;
                  absorb_out.amount = HDR + total;
                  probe_out.shamt   = nf ? 2'd2 : 2'd1;
                  probe_out.shl     = 1'b1;
                  seg_in = nf ? next2 : next1;
               end else begin
                  seg_in.free = 1'b1;
                  seg_in.size = total;
                  probe_out.shl   = nf;
                  probe_out.shamt = nf ? 2'd1 : 2'd0;
               end
            end
         end
      end
      if (absorb_in.valid) begin
         seg_in.size = seg_ff.size + absorb_in.amount;
      end
      if (init) begin
         seg_in = init_seg;
      end
   end

   assign seg_out = seg_ff;

endmodule
`default_nettype wire

// ----- design/first_fit_heap_allocator_top.sv -----
// Top level: request control, segment cell row and response register.
// A response is registered after the request word has passed every cell in the row.
// A new request waits until the last word has left the row and its response is taken.
// The request word visits every cell once; splits and merges ripple along with it.
// Reset and every register write reload cell 0 in the following cycle; no request
// is taken in that cycle.
`default_nettype none
module first_fit_heap_allocator_top #(
   parameter int MAX_SEGMENTS = 64,
   parameter int HEADER_BYTES = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_request_size,
   input  wire logic [31:0] req_free_address,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_address,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_write_data
);
   import ffha_pkg::*;

   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [31:0] HDR = 32'(HEADER_BYTES);

   logic          busy_ff, init_ff, rsp_valid_ff;
   logic [CW-1:0] count_ff;
   logic [31:0]   base_ff, bytes_ff, rsp_address_ff;
   logic [1:0]    rsp_status_ff;

   probe_type  probe_link  [MAX_SEGMENTS+1];
   seg_type    seg_link    [MAX_SEGMENTS+2];
   absorb_type absorb_link [MAX_SEGMENTS+1];
   logic [MAX_SEGMENTS-1:0] probe_live;

   seg_type   init_seg;
   probe_type inject, pe;
   logic      accept;
   logic [31:0] rounded;

   assign req_ready = !busy_ff && !init_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rounded   = (req_request_size + 32'd3) & ~32'd3;

   always_comb begin
      inject           = '0;
      inject.valid     = accept;
      inject.mode      = req_mode;
      if (req_mode == MODE_FREE) begin
         inject.key    = req_free_address;
         inject.done   = (req_free_address == 32'd0);
         inject.status = ST_NULL;
      end else begin
         inject.key    = rounded;
         inject.done   = (req_request_size > MAX_ROUNDABLE);
         inject.status = ST_OOM;
      end
   end

   assign init_seg.addr = base_ff + HDR;
   assign init_seg.size = (bytes_ff >= HDR) ? bytes_ff - HDR : 32'd0;
   assign init_seg.free = 1'b1;

   assign probe_link[0]             = inject;
   assign seg_link[MAX_SEGMENTS]    = '0;
   assign seg_link[MAX_SEGMENTS+1]  = '0;
   assign absorb_link[MAX_SEGMENTS] = '0;

   for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
      ffha_cell #(
         .MAX_SEGMENTS(MAX_SEGMENTS),
         .HEADER_BYTES(HEADER_BYTES),
         .IDX(k),
         .CW(CW)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .probe_in(probe_link[k]),
         .probe_out(probe_link[k+1]),
         .count(count_ff),
         .next1(seg_link[k+1]),
         .next2(seg_link[k+2]),
         .init(init_ff && (k == 0)),
         .init_seg(init_seg),
         .absorb_in(absorb_link[k+1]),
         .absorb_out(absorb_link[k]),
         .seg_out(seg_link[k])
      );
      assign probe_live[k] = probe_link[k+1].valid;
   end

   assign pe = probe_link[MAX_SEGMENTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CW'(1);
         base_ff      <= HEAP_BASE_RST;
         bytes_ff     <= HEAP_BYTES_RST;
      end else begin
         if (init_ff) begin
            count_ff <= CW'(1);
         end
         init_ff <= csr_write_enable;
         if (csr_write_enable) begin
            if (csr_index == REG_HEAP_BASE) begin
               base_ff <= csr_write_data;
            end else begin
               bytes_ff <= csr_write_data;
            end
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end
         if (pe.valid) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            if (pe.mode == MODE_ALLOC && pe.carry) begin
               count_ff <= count_ff + CW'(1);
            end else if (pe.mode == MODE_FREE && pe.done && pe.status == ST_OK) begin
               count_ff <= count_ff - CW'(pe.shamt);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pe.valid) begin
         if (pe.done) begin
            rsp_status_ff <= pe.status;
         end else begin
            rsp_status_ff <= (pe.mode == MODE_FREE) ? ST_BAD : ST_OOM;
         end
         rsp_address_ff <= (pe.done && pe.status == ST_OK && pe.mode == MODE_ALLOC)
                           ? pe.addr : 32'd0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      $onehot0(probe_live))
      else $error("more than one request word in the cell row");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count out of range");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("response pending while a request is in flight");

   a_inject: assert property (@(posedge clock) disable iff (reset)
      accept |=> probe_live[0] && busy_ff)
      else $error("accepted word did not enter the first cell");

endmodule
`default_nettype wire
